### design/spdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_pkg
// Types and constants shared by the serial data-flash read responder.
// ----------------------------------------------------------------------------
package spdf_pkg;

    localparam logic [1:0] MODE_XFER   = 2'd0;
    localparam logic [1:0] MODE_DESEL  = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;

    localparam logic [7:0] OP_STATUS_OLD = 8'h57;
    localparam logic [7:0] OP_STATUS     = 8'hD7;
    localparam logic [7:0] STATUS_VALUE  = 8'h9C;
    localparam logic [7:0] IDLE_BYTE     = 8'hFF;
    localparam logic [2:0] DUMMY_COUNT   = 3'd4;

    localparam int PAGE_FIELD_W = 11;
    localparam int OFFSET_W     = 9;
    localparam int ADDR_WORD_W  = 24;

    typedef enum logic [2:0] {
        PH_CMD    = 3'd0,
        PH_ADDR   = 3'd1,
        PH_STATUS = 3'd2,
        PH_DUMMY  = 3'd3,
        PH_STREAM = 3'd4
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic       use_mem;
        logic [7:0] data;
    } t_xfer_res;

endpackage

### design/spi_dataflash_read_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_dataflash_read_responder
// Serial data-flash slave answering one SPI byte per transfer, with a
// loadable page-organized image store.
//
//   Channel  Direction  Handshake               Payload
//   in       input      i_in_valid / o_in_stall  i_mode, i_mosi_byte,
//                                                i_load_addr, i_load_data
//   out      output     o_out_valid / i_out_stall o_miso_byte
//
// One item per cycle when not stalled; answers pass the s1 and answer stages.
// Stream bytes come from the store's single read port, read at acceptance.
// After reset the store is filled with 0xFF, one byte a cycle, across all
// PAGE_SIZE*NUM_PAGES bytes (540672 by default); no item is taken meanwhile.
// A held answer stalls the input only once the s1 stage is also full.
// ----------------------------------------------------------------------------
module spi_dataflash_read_responder
    import spdf_pkg::*;
#(
    parameter int PAGE_SIZE = 264,
    parameter int NUM_PAGES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_mosi_byte,
    input  logic [19:0] i_load_addr,
    input  logic [7:0]  i_load_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_miso_byte
);

    localparam int FLASH_BYTES = PAGE_SIZE * NUM_PAGES;
    localparam int AW = (FLASH_BYTES > 1) ? $clog2(FLASH_BYTES) : 1;
    localparam logic [AW-1:0] ADDR_LAST = AW'(FLASH_BYTES - 1);
    localparam logic [20:0]   FLASH_LIM = 21'(FLASH_BYTES);

    logic                   r_clr_busy;
    logic [AW-1:0]          r_clr_addr;
    logic                   r_s1_valid, r_s1_use_mem;
    logic [7:0]             r_s1_data;
    logic                   r_out_valid;
    logic [7:0]             r_out_data;

    logic                   acc;
    logic                   s1_adv;
    logic                   out_load;
    t_xfer_res              res;
    logic [AW-1:0]          rd_addr;
    logic                   calc_go, calc_done;
    logic [ADDR_WORD_W-1:0] calc_addr;
    logic [AW-1:0]          calc_ptr;
    logic                   load_we;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || out_load;
    assign o_in_stall = r_clr_busy || !s1_adv;
    assign acc        = i_in_valid && !o_in_stall;

    assign load_we   = acc && (i_mode == MODE_LOAD) && ({1'b0, i_load_addr} < FLASH_LIM);
    assign ram_we    = r_clr_busy || load_we;
    assign ram_waddr = r_clr_busy ? r_clr_addr : i_load_addr[AW-1:0];
    assign ram_wdata = r_clr_busy ? IDLE_BYTE : i_load_data;

    spdf_seq #(
        .PAGE_SIZE (PAGE_SIZE),
        .NUM_PAGES (NUM_PAGES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_mode      (i_mode),
        .i_mosi_byte (i_mosi_byte),
        .i_calc_done (calc_done),
        .i_calc_ptr  (calc_ptr),
        .o_res       (res),
        .o_rd_addr   (rd_addr),
        .o_calc_go   (calc_go),
        .o_calc_addr (calc_addr)
    );

    spdf_addr #(
        .PAGE_SIZE (PAGE_SIZE),
        .NUM_PAGES (NUM_PAGES)
    ) u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (calc_go),
        .i_addr_word (calc_addr),
        .o_done      (calc_done),
        .o_ptr       (calc_ptr)
    );

    spdf_ram #(
        .WIDTH (8),
        .DEPTH (FLASH_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (res.valid && res.use_mem),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_LAST) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) r_s1_valid <= res.valid;
            if (out_load) r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_use_mem <= res.use_mem;
            r_s1_data    <= res.data;
        end
        if (out_load) begin
            r_out_data <= r_s1_use_mem ? ram_rdata : r_s1_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_miso_byte = r_out_data;

endmodule

### design/spdf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is enabled.
// ----------------------------------------------------------------------------
module spdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/spdf_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_addr
// Address pipeline: split page and offset, clamp offset, reduce page
// modulo the page count in two steps, multiply by page size, add offset.
// ----------------------------------------------------------------------------
module spdf_addr
    import spdf_pkg::*;
#(
    parameter int PAGE_SIZE = 264,
    parameter int NUM_PAGES = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_go,
    input  logic [ADDR_WORD_W-1:0] i_addr_word,
    output logic                   o_done,
    output logic [((PAGE_SIZE * NUM_PAGES > 1) ? $clog2(PAGE_SIZE * NUM_PAGES) : 1)-1:0] o_ptr
);

    localparam int FLASH_BYTES = PAGE_SIZE * NUM_PAGES;
    localparam int AW = (FLASH_BYTES > 1) ? $clog2(FLASH_BYTES) : 1;
    localparam logic [OFFSET_W:0] PS_CMP = (OFFSET_W + 1)'(PAGE_SIZE);
    localparam logic [OFFSET_W-1:0] OFF_MAX = OFFSET_W'(PAGE_SIZE - 1);

    function automatic logic [PAGE_FIELD_W-1:0] f_reduce(
        input logic [PAGE_FIELD_W-1:0] p,
        input int                      hi,
        input int                      lo
    );
        logic [PAGE_FIELD_W-1:0]   v;
        logic [2*PAGE_FIELD_W-1:0] sh;
        v = p;
        for (int k = PAGE_FIELD_W - 1; k >= 0; k--) begin
            sh = (2 * PAGE_FIELD_W)'(NUM_PAGES) << k;
            if (k <= hi && k >= lo && sh < (2 * PAGE_FIELD_W)'(1 << PAGE_FIELD_W)
                    && {{PAGE_FIELD_W{1'b0}}, v} >= sh) begin
                v = v - sh[PAGE_FIELD_W-1:0];
            end
        end
        return v;
    endfunction

    logic                    r_a_v, r_b_v, r_c_v, r_d_v;
    logic [PAGE_FIELD_W-1:0] r_a_page, r_b_page, r_c_page;
    logic [OFFSET_W-1:0]     r_a_off, r_b_off, r_c_off, r_d_off;
    logic [AW-1:0]           r_d_prod;
    logic [OFFSET_W-1:0]     in_off;
    logic [20:0]             prod_w;
    logic [20:0]             sum_w;

    assign in_off = i_addr_word[OFFSET_W-1:0];
    assign prod_w = 21'(r_c_page) * 21'(PAGE_SIZE);
    assign sum_w  = 21'(r_d_prod) + 21'(r_d_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            r_a_v <= i_go;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_page <= i_addr_word[OFFSET_W+PAGE_FIELD_W-1:OFFSET_W];
        r_a_off  <= ({1'b0, in_off} >= PS_CMP) ? OFF_MAX : in_off;
        r_b_page <= f_reduce(r_a_page, PAGE_FIELD_W - 1, 6);
        r_b_off  <= r_a_off;
        r_c_page <= f_reduce(r_b_page, 5, 0);
        r_c_off  <= r_b_off;
        r_d_prod <= prod_w[AW-1:0];
        r_d_off  <= r_c_off;
    end

    assign o_done = r_d_v;
    assign o_ptr  = sum_w[AW-1:0];

endmodule

### design/spdf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_seq
// Command sequencer: phase machine, address byte capture, dummy count,
// image flag and stream read pointer.
// ----------------------------------------------------------------------------
module spdf_seq
    import spdf_pkg::*;
#(
    parameter int PAGE_SIZE = 264,
    parameter int NUM_PAGES = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_acc,
    input  logic [1:0]             i_mode,
    input  logic [7:0]             i_mosi_byte,
    input  logic                   i_calc_done,
    input  logic [((PAGE_SIZE * NUM_PAGES > 1) ? $clog2(PAGE_SIZE * NUM_PAGES) : 1)-1:0] i_calc_ptr,
    output t_xfer_res              o_res,
    output logic [((PAGE_SIZE * NUM_PAGES > 1) ? $clog2(PAGE_SIZE * NUM_PAGES) : 1)-1:0] o_rd_addr,
    output logic                   o_calc_go,
    output logic [ADDR_WORD_W-1:0] o_calc_addr
);

    localparam int FLASH_BYTES = PAGE_SIZE * NUM_PAGES;
    localparam int AW = (FLASH_BYTES > 1) ? $clog2(FLASH_BYTES) : 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(FLASH_BYTES - 1);

    t_phase        r_phase, n_phase;
    logic [7:0]    r_addr_b0, n_addr_b0;
    logic [7:0]    r_addr_b1, n_addr_b1;
    logic [1:0]    r_addr_cnt, n_addr_cnt;
    logic [2:0]    r_dummy, n_dummy;
    logic          r_img, n_img;
    logic [AW-1:0] r_ptr, n_ptr;
    logic          xfer;
    logic [AW-1:0] ptr_inc;

    assign xfer    = i_acc && (i_mode == MODE_XFER) && r_img;
    assign ptr_inc = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_phase = r_phase;
        if (i_acc && i_mode == MODE_DESEL) begin
            n_phase = PH_CMD;
        end else if (xfer) begin
            case (r_phase)
                PH_CMD: begin
                    n_phase = (i_mosi_byte inside {OP_STATUS, OP_STATUS_OLD})
                            ? PH_STATUS : PH_ADDR;
                end
                PH_ADDR: begin
                    if (r_addr_cnt[1]) n_phase = PH_DUMMY;
                end
                PH_DUMMY: begin
                    if (r_dummy == '0) n_phase = PH_STREAM;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_addr_b0  = r_addr_b0;
        n_addr_b1  = r_addr_b1;
        n_addr_cnt = r_addr_cnt;
        n_dummy    = r_dummy;
        n_img      = r_img;
        n_ptr      = r_ptr;
        o_calc_go  = 1'b0;
        o_res      = '{valid: i_acc && (i_mode == MODE_XFER), use_mem: 1'b0,
                       data: IDLE_BYTE};
        if (i_acc && i_mode == MODE_DESEL) n_addr_cnt = '0;
        if (i_acc && i_mode == MODE_LOAD)  n_img = 1'b1;
        if (xfer) begin
            case (r_phase)
                PH_CMD: n_addr_cnt = '0;
                PH_ADDR: begin
                    if (!r_addr_cnt[1]) begin
                        if (r_addr_cnt[0]) n_addr_b1 = i_mosi_byte;
                        else               n_addr_b0 = i_mosi_byte;
                        n_addr_cnt = r_addr_cnt + 1'b1;
                    end else begin
                        o_calc_go  = 1'b1;
                        n_addr_cnt = '0;
                        n_dummy    = DUMMY_COUNT;
                    end
                end
                PH_STATUS: o_res.data = STATUS_VALUE;
                PH_DUMMY: begin
                    if (r_dummy != '0) begin
                        n_dummy = r_dummy - 1'b1;
                    end else begin
                        o_res.use_mem = 1'b1;
                        n_ptr = ptr_inc;
                    end
                end
                default: begin
                    o_res.use_mem = 1'b1;
                    n_ptr = ptr_inc;
                end
            endcase
        end
        if (i_calc_done) n_ptr = i_calc_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CMD;
            r_addr_b0  <= '0;
            r_addr_b1  <= '0;
            r_addr_cnt <= '0;
            r_dummy    <= '0;
            r_img      <= 1'b0;
            r_ptr      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_addr_b0  <= n_addr_b0;
            r_addr_b1  <= n_addr_b1;
            r_addr_cnt <= n_addr_cnt;
            r_dummy    <= n_dummy;
            r_img      <= n_img;
            r_ptr      <= n_ptr;
        end
    end

    assign o_rd_addr   = r_ptr;
    assign o_calc_addr = {r_addr_b0, r_addr_b1, i_mosi_byte};

endmodule
